/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every rising edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// implication checked in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, trig, prop)

`endif

`endif

/* rtl/core/mts_pkg.sv */
// shared types and constants of the max tracking stack
package mts_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = 7;
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 6;
  localparam int STAT_W  = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic commit;
  } ctrl_cmd_t;

endpackage

/* rtl/core/mts_ctrl.sv */
// sequencing state machine of the max tracking stack
module mts_ctrl import mts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_READ:   cmd.rd = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

/* rtl/core/mts_dp.sv */
// datapath of the max tracking stack: storage, fill count and result registers
module mts_dp import mts_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  input  logic        [KIND_W-1:0] kind,
  input  logic signed [DATA_W-1:0] value,
  input  logic       [INDEX_W-1:0] index,
  output logic                     done,
  output logic signed [DATA_W-1:0] data,
  output logic        [STAT_W-1:0] status,
  output logic signed [DATA_W-1:0] current_max,
  output logic                     max_valid,
  output logic         [CNT_W-1:0] count
);

  logic        [KIND_W-1:0]  req_kind;
  logic signed [DATA_W-1:0]  req_value;
  logic       [INDEX_W-1:0]  req_index;

  logic         [CNT_W-1:0]  fill_count;
  logic         [CNT_W-1:0]  fill_count_next;
  logic signed [DATA_W-1:0]  top_max;
  logic signed [DATA_W-1:0]  top_max_next;

  logic signed [DATA_W-1:0]  entries_mem [DEPTH];
  logic signed [DATA_W-1:0]  max_mem [DEPTH];
  logic signed [DATA_W-1:0]  rd_entry;
  logic signed [DATA_W-1:0]  rd_max;

  logic         [ADDR_W-1:0] entry_addr;
  logic         [ADDR_W-1:0] max_addr;
  logic         [ADDR_W-1:0] push_addr;
  logic                      push_ok;
  logic signed [DATA_W-1:0]  push_max;
  logic signed [DATA_W-1:0]  data_next;
  logic        [STAT_W-1:0]  status_next;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind  <= kind;
      req_value <= value;
      req_index <= index;
    end
  end

  // pop reads the top entry and the running max one below it
  assign entry_addr = (req_kind == KIND_POP) ? ADDR_W'(fill_count - CNT_W'(1))
                                             : ADDR_W'(req_index);
  assign max_addr   = ADDR_W'(fill_count - CNT_W'(2));
  assign push_addr  = ADDR_W'(fill_count);

  assign push_ok  = (req_kind == KIND_PUSH) && (fill_count != CNT_W'(DEPTH));
  assign push_max = ((fill_count != '0) && (top_max > req_value)) ? top_max : req_value;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_entry <= entries_mem[entry_addr];
      rd_max   <= max_mem[max_addr];
    end
    if (cmd.commit && push_ok) begin
      entries_mem[push_addr] <= req_value;
      max_mem[push_addr]     <= push_max;
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    top_max_next    = top_max;
    data_next       = '0;
    status_next     = STAT_OK;
    case (req_kind)
      KIND_PUSH: begin
        if (push_ok) begin
          fill_count_next = fill_count + CNT_W'(1);
          top_max_next    = push_max;
        end else begin
          status_next = STAT_FULL;
        end
      end
      KIND_POP: begin
        if (fill_count == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          fill_count_next = fill_count - CNT_W'(1);
          top_max_next    = rd_max;
          data_next       = rd_entry;
        end
      end
      KIND_READ: begin
        if (CNT_W'(req_index) < fill_count) begin
          data_next = rd_entry;
        end else begin
          status_next = STAT_EMPTY;
        end
      end
      default: status_next = STAT_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      done       <= 1'b0;
      count      <= '0;
      max_valid  <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        fill_count <= fill_count_next;
        count      <= fill_count_next;
        max_valid  <= (fill_count_next != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top_max     <= top_max_next;
      data        <= data_next;
      status      <= status_next;
      current_max <= (fill_count_next != '0) ? top_max_next : '0;
    end
  end

endmodule

/* rtl/core/max_tracking_stack.sv */
// max tracking stack: one request at a time, result strobed on done
// sequence: the accepting edge loads the request, then a registered memory read, then commit;
// done is registered from commit and is high for one cycle; a new request is not taken
// before the last one has committed, and busy is low again in the cycle that carries done
// reset: synchronous rst empties the stack and clears done; storage is not cleared
// the receiver cannot stall, so every result is shown exactly once
`include "assert_macros.svh"

module max_tracking_stack import mts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic         [KIND_W-1:0] kind,
  input  logic signed  [DATA_W-1:0] value,
  input  logic        [INDEX_W-1:0] index,
  output logic                      done,
  output logic signed  [DATA_W-1:0] data,
  output logic         [STAT_W-1:0] status,
  output logic signed  [DATA_W-1:0] current_max,
  output logic                      max_valid,
  output logic          [CNT_W-1:0] count
);

  // command bundle from the sequencer to the datapath
  ctrl_cmd_t cmd;

  // sequencer: idle, memory read, commit
  mts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: entry and running-max memories, fill count, result registers
  mts_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .kind        (kind),
    .value       (value),
    .index       (index),
    .done        (done),
    .data        (data),
    .status      (status),
    .current_max (current_max),
    .max_valid   (max_valid),
    .count       (count)
  );

  // a result only appears once the sequencer is back to idle
  `ASSERT_ALWAYS(a_done_idle, clk, rst, !done || !busy)
  // an accepted request holds the block busy in the next cycle
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // the stack never reports more entries than it has room for
  `ASSERT_ALWAYS(a_count_bound, clk, rst, !done || (count <= CNT_W'(DEPTH)))
  // max flag agrees with the element count
  `ASSERT_ALWAYS(a_max_valid, clk, rst, !done || (max_valid == (count != '0)))

endmodule

/* dv/testbench.sv */
// testbench for the max tracking stack: random and directed requests checked against a predictor
module testbench import mts_pkg::*;;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 700;
  // requests after this point go in back to back
  localparam int QUIET_TAIL = 150;
  // watchdog bound, well above the slowest correct run
  localparam int CYCLE_LIMIT = 100000;
  // settle time after the drain, beyond the latency of the block
  localparam int SETTLE_CYCLES = 8;

  // one result as the block shows it on its ports
  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic        [STAT_W-1:0] status;
    logic signed [DATA_W-1:0] current_max;
    logic                     max_valid;
    logic         [CNT_W-1:0] count;
  } stack_result_t;

  // mirror of the stack with a running maximum per depth
  class max_stack_tracker;
    logic signed [DATA_W-1:0] stored[DEPTH];
    logic signed [DATA_W-1:0] running_max[DEPTH];
    int unsigned fill;
    stack_result_t awaited[$];
    int unsigned failures;

    function new();
      fill = 0;
      failures = 0;
    endfunction

    // predict the result of one accepted request and queue it
    function void note_request(logic [KIND_W-1:0] k, logic signed [DATA_W-1:0] v,
                               logic [INDEX_W-1:0] i);
      stack_result_t r;
      logic signed [DATA_W-1:0] m;
      r.data = '0;
      r.status = STAT_OK;
      case (k)
        KIND_PUSH: begin
          if (fill >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            m = v;
            if (fill > 0 && running_max[fill-1] > m) m = running_max[fill-1];
            stored[fill] = v;
            running_max[fill] = m;
            fill++;
          end
        end
        KIND_POP: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            fill--;
            r.data = stored[fill];
          end
        end
        KIND_READ: begin
          if (i < fill) r.data = stored[i];
          else r.status = STAT_EMPTY;
        end
        default: r.status = STAT_EMPTY;
      endcase
      if (fill > 0) r.current_max = running_max[fill-1];
      else r.current_max = '0;
      r.max_valid = (fill > 0);
      r.count = fill[CNT_W-1:0];
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [DATA_W-1:0] want,
                                logic signed [DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    // compare one strobed result with the oldest prediction
    function void check_result(stack_result_t got);
      stack_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %0d status %0d",
                 $time, got.data, got.status);
        failures++;
      end else begin
        want = awaited.pop_front();
        compare_field("data", want.data, got.data);
        compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
        compare_field("current_max", want.current_max, got.current_max);
        compare_field("max_valid", DATA_W'(want.max_valid), DATA_W'(got.max_valid));
        compare_field("count", DATA_W'(want.count), DATA_W'(got.count));
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic         [KIND_W-1:0] kind;
  logic signed  [DATA_W-1:0] value;
  logic        [INDEX_W-1:0] index;
  logic                      done;
  logic signed  [DATA_W-1:0] data;
  logic         [STAT_W-1:0] status;
  logic signed  [DATA_W-1:0] current_max;
  logic                      max_valid;
  logic          [CNT_W-1:0] count;

  max_stack_tracker tracker = new();
  int sent;
  bit gappy;

  max_tracking_stack i_dut (.*);

  always #4 clk = ~clk;

  // sample at the rising edge: results first, then the request taken at that edge
  always @(posedge clk) begin
    stack_result_t seen;
    if (!rst) begin
      if (done) begin
        seen.data = data;
        seen.status = status;
        seen.current_max = current_max;
        seen.max_valid = max_valid;
        seen.count = count;
        tracker.check_result(seen);
      end
      if (start && !busy) tracker.note_request(kind, value, index);
    end
  end

  // watchdog on the whole run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(logic [KIND_W-1:0] k, logic signed [DATA_W-1:0] v,
                              logic [INDEX_W-1:0] i);
    start = 1'b1;
    kind  = k;
    value = v;
    index = i;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  task automatic idle_for(int unsigned n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // hold requests back until every predicted result has come out
  task automatic drain_results();
    start = 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk);
  endtask

  // maybe insert an idle burst, never in the quiet tail
  task automatic maybe_gap();
    if (gappy && sent < RANDOM_REQUESTS - QUIET_TAIL && $urandom_range(0, 2) == 0)
      idle_for($urandom_range(1, 9));
  endtask

  // values mix extremes, small numbers that tie and cross, and full-width noise
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3, 4: return $signed($urandom_range(0, 40)) - 20;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if (tracker.fill > 0 && $urandom_range(0, 4) != 0)
      return INDEX_W'($urandom_range(0, tracker.fill - 1));
    return INDEX_W'($urandom_range(0, 63));
  endfunction

  initial begin
    int mode;
    int n;
    int r;
    clk   = 1'b0;
    rst   = 1'b1;
    start = 1'b0;
    kind  = KIND_PUSH;
    value = '0;
    index = '0;
    sent  = 0;
    gappy = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every operation, empty pop, reads past the top, unused kind
    send_request(KIND_PUSH, 32'sd0, 6'd63);
    send_request(KIND_PUSH, 32'sh7fff_ffff, 6'd0);
    send_request(KIND_PUSH, 32'sh8000_0000, 6'd0);
    send_request(KIND_PUSH, -32'sd1, 6'd0);
    send_request(KIND_READ, 32'sh7fff_ffff, 6'd0);
    send_request(KIND_READ, 32'sd0, 6'd3);
    send_request(KIND_READ, 32'sd0, 6'd4);
    send_request(KIND_READ, 32'sd0, 6'd63);
    send_request(KIND_UNUSED, -32'sd1, 6'd63);
    send_request(KIND_POP, 32'sh8000_0000, 6'd63);
    send_request(KIND_POP, 32'sd0, 6'd0);
    send_request(KIND_POP, 32'sd0, 6'd0);
    send_request(KIND_POP, 32'sd0, 6'd0);
    send_request(KIND_POP, 32'sd0, 6'd0);
    send_request(KIND_READ, 32'sd0, 6'd0);
    send_request(KIND_PUSH, -32'sd5, 6'd0);
    send_request(KIND_PUSH, -32'sd7, 6'd0);
    send_request(KIND_PUSH, -32'sd2, 6'd0);
    send_request(KIND_PUSH, -32'sd2, 6'd0);
    send_request(KIND_POP, 32'sd0, 6'd0);
    send_request(KIND_POP, 32'sd0, 6'd0);
    send_request(KIND_POP, 32'sd0, 6'd0);

    // pause until the block has answered everything
    drain_results();
    sent = 0;

    // random part, first sequence always fills the stack to overflow
    mode = 0;
    while (sent < RANDOM_REQUESTS) begin
      gappy = $urandom_range(0, 2) != 0;
      case (mode)
        0, 1, 2: begin
          // fill to the top, then push into a full stack
          while (tracker.fill < DEPTH) begin
            maybe_gap();
            send_request(KIND_PUSH, pick_value(), INDEX_W'($urandom_range(0, 63)));
          end
          repeat ($urandom_range(1, 3)) begin
            maybe_gap();
            send_request(KIND_PUSH, pick_value(), INDEX_W'($urandom_range(0, 63)));
          end
        end
        3, 4: begin
          // unwind to empty, then pop an empty stack
          while (tracker.fill > 0) begin
            maybe_gap();
            if ($urandom_range(0, 3) == 0) send_request(KIND_READ, $urandom(), pick_index());
            else send_request(KIND_POP, $urandom(), INDEX_W'($urandom_range(0, 63)));
          end
          repeat ($urandom_range(1, 2)) begin
            maybe_gap();
            send_request(KIND_POP, $urandom(), INDEX_W'($urandom_range(0, 63)));
          end
        end
        5, 6, 7, 8: begin
          // mixed traffic around the current depth
          n = $urandom_range(10, 40);
          repeat (n) begin
            maybe_gap();
            r = $urandom_range(0, 19);
            if (r < 9) send_request(KIND_PUSH, pick_value(), INDEX_W'($urandom_range(0, 63)));
            else if (r < 14) send_request(KIND_POP, $urandom(), INDEX_W'($urandom_range(0, 63)));
            else if (r < 19) send_request(KIND_READ, $urandom(), pick_index());
            else send_request(KIND_UNUSED, $urandom(), INDEX_W'($urandom_range(0, 63)));
          end
        end
        default: begin
          // noise: any kind, any value, any index
          n = $urandom_range(5, 15);
          repeat (n) begin
            maybe_gap();
            send_request(KIND_W'($urandom_range(0, 3)), $urandom(),
                         INDEX_W'($urandom_range(0, 63)));
          end
        end
      endcase
      if (sent < RANDOM_REQUESTS - QUIET_TAIL && $urandom_range(0, 7) == 0) drain_results();
      mode = $urandom_range(0, 9);
    end

    // wind down and let the last results through
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.awaited.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               tracker.awaited.size());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
